### hw/rtl/ncc_pkg.sv
// Shared types and constants for the nested comment classifier.
// Used by every RTL module of the block.
`default_nettype none

package ncc_pkg;

  // Result classes as carried on the output channel
  typedef enum logic [2:0] {
    CLS_CODE    = 3'd0,
    CLS_NEWLINE = 3'd1,
    CLS_LINE    = 3'd2,
    CLS_BLOCK   = 3'd3,
    CLS_END     = 3'd4
  } cls_e;

  // Lexer modes of the front end
  typedef enum logic [2:0] {
    M_CODE  = 3'd0,
    M_HOLD  = 3'd1,
    M_BLOCK = 3'd2,
    M_LINE  = 3'd3,
    M_DIRL  = 3'd4
  } mode_e;

  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_BAR  = 8'h7C;
  localparam logic [7:0] CH_NL   = 8'h0A;

  localparam int unsigned BUF_DEPTH = 9;
  localparam int unsigned NUM_WORDS = 3;

  // Directive words, first byte in the top byte lane
  localparam logic [71:0] DIR_WORDS [NUM_WORDS] = '{
    {"#extern", 16'h0000},
    "#register",
    {"#include", 8'h00}
  };
  localparam logic [3:0] DIR_LEN [NUM_WORDS] = '{4'd7, 4'd9, 4'd8};

  // One result on its way from the front end to the back end
  typedef struct packed {
    logic [7:0] ch;
    cls_e       cls;
    logic       ts;
    logic       last;
    logic       vis;
  } entry_t;

  // Byte at position idx of directive word k
  function automatic logic [7:0] dir_char(input int k, input logic [3:0] idx);
    logic [71:0] w;
    w = DIR_WORDS[k];
    return w[8 * (8 - int'(idx)) +: 8];
  endfunction

endpackage

`default_nettype wire

### hw/rtl/ncc_in_if.sv
// Input channel of the classifier: one source byte or an end item.
// Depends on nothing.
`default_nettype none

interface ncc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       end_marker;

  modport source (output valid, output in_char, output end_marker, input ready);
  modport sink   (input valid, input in_char, input end_marker, output ready);
endinterface

`default_nettype wire

### hw/rtl/ncc_out_if.sv
// Output channel of the classifier: one labelled byte with its position.
// Depends on nothing; widths set by parameters.
`default_nettype none

interface ncc_out_if #(
  parameter int unsigned LINE_BITS   = 24,
  parameter int unsigned COLUMN_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [7:0]             out_char;
  logic [2:0]             char_class;
  logic                   token_start;
  logic [LINE_BITS-1:0]   line_number;
  logic [COLUMN_BITS-1:0] column_number;
  logic                   last_of_run;

  modport source (output valid, output out_char, output char_class, output token_start,
                  output line_number, output column_number, output last_of_run,
                  input ready);
  modport sink   (input valid, input out_char, input char_class, input token_start,
                  input line_number, input column_number, input last_of_run,
                  output ready);
endinterface

`default_nettype wire

### hw/rtl/ncc_cfg_if.sv
// Configuration write channel carrying the drop_comments bit.
// Depends on nothing.
`default_nettype none

interface ncc_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/ncc_front.sv
// Front end: accepts bytes, runs the lexer and pushes one result a cycle while the queue has room.
// Depends on ncc_pkg; feeds ncc_queue.
`default_nettype none

module ncc_front import ncc_pkg::*; #(
  parameter int unsigned MAX_DEPTH = 255,
  parameter int unsigned DEPTH_BITS = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_char_i,
  input  wire logic       end_marker_i,
  input  wire logic       cfg_valid_i,
  input  wire logic       cfg_data_i,
  input  wire logic       q_full_i,
  output logic            push_o,
  output entry_t          push_entry_o
);

  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = DEPTH_BITS'(MAX_DEPTH);

  mode_e                 mode_q, mode_d;
  logic [DEPTH_BITS-1:0] depth_q, depth_d;
  logic [7:0]            pend_q, pend_d;
  logic                  pend_v_q, pend_v_d;
  logic [7:0]            buf_q [BUF_DEPTH];
  logic                  buf_we;
  logic [3:0]            buf_wa;
  logic [3:0]            cnt_q, cnt_d;
  logic [2:0]            cand_q, cand_d;
  logic                  ntf_q, ntf_d;
  logic                  drop_q;
  logic                  fl_act_q, fl_act_d;
  logic [3:0]            fl_idx_q, fl_idx_d;
  logic [3:0]            fl_n_q, fl_n_d;
  cls_e                  fl_cls_q, fl_cls_d;
  logic                  tail_v_q, tail_v_d;
  logic [7:0]            tail_ch_q, tail_ch_d;
  cls_e                  tail_cls_q, tail_cls_d;
  logic                  tail_ts_q, tail_ts_d;
  logic [2:0]            live;
  logic                  done_word;
  logic                  accept;

  function automatic entry_t mk(input logic [7:0] ch, input cls_e cls, input logic ts,
                                input logic last, input logic drop);
    entry_t e;
    e.ch   = ch;
    e.cls  = cls;
    e.ts   = ts;
    e.last = last;
    e.vis  = !(drop && (cls == CLS_LINE || cls == CLS_BLOCK));
    return e;
  endfunction

  assign in_ready_o = !fl_act_q && !tail_v_q && !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Match the incoming byte against the live directive words
  always_comb begin
    live      = '0;
    done_word = 1'b0;
    for (int k = 0; k < NUM_WORDS; k++) begin
      if (cand_q[k] && cnt_q < DIR_LEN[k] && dir_char(k, cnt_q) == in_char_i) begin
        live[k] = 1'b1;
        if (DIR_LEN[k] == cnt_q + 4'd1) done_word = 1'b1;
      end
    end
  end

  // Lexer step and result sequencing
  always_comb begin
    mode_d     = mode_q;
    depth_d    = depth_q;
    pend_d     = pend_q;
    pend_v_d   = pend_v_q;
    cnt_d      = cnt_q;
    cand_d     = cand_q;
    ntf_d      = ntf_q;
    fl_act_d   = fl_act_q;
    fl_idx_d   = fl_idx_q;
    fl_n_d     = fl_n_q;
    fl_cls_d   = fl_cls_q;
    tail_v_d   = tail_v_q;
    tail_ch_d  = tail_ch_q;
    tail_cls_d = tail_cls_q;
    tail_ts_d  = tail_ts_q;
    buf_we     = 1'b0;
    buf_wa     = cnt_q;
    push_o     = 1'b0;
    push_entry_o = mk(8'h00, CLS_CODE, 1'b0, 1'b0, drop_q);

    if (fl_act_q) begin
      // Drain held bytes
      if (!q_full_i) begin
        push_o       = 1'b1;
        push_entry_o = mk(buf_q[fl_idx_q], fl_cls_q, fl_idx_q == 4'd0,
                          (fl_idx_q == fl_n_q - 4'd1) && !tail_v_q, drop_q);
        fl_idx_d     = fl_idx_q + 4'd1;
        if (fl_idx_q == fl_n_q - 4'd1) fl_act_d = 1'b0;
      end
    end else if (tail_v_q) begin
      if (!q_full_i) begin
        push_o       = 1'b1;
        push_entry_o = mk(tail_ch_q, tail_cls_q, tail_ts_q, 1'b1, drop_q);
        tail_v_d     = 1'b0;
      end
    end else if (accept) begin
      if (end_marker_i) begin
        // Flush held bytes, then the end marker; return to reset state
        tail_v_d   = 1'b1;
        tail_ch_d  = 8'h00;
        tail_cls_d = CLS_END;
        tail_ts_d  = 1'b1;
        if (mode_q == M_HOLD && cnt_q != 4'd0) begin
          fl_act_d = 1'b1;
          fl_idx_d = '0;
          fl_n_d   = cnt_q;
          fl_cls_d = CLS_LINE;
        end else if (mode_q == M_BLOCK && pend_v_q) begin
          push_o       = 1'b1;
          push_entry_o = mk(pend_q, CLS_BLOCK, 1'b0, 1'b0, drop_q);
        end
        mode_d   = M_CODE;
        depth_d  = '0;
        pend_d   = '0;
        pend_v_d = 1'b0;
        cnt_d    = '0;
        cand_d   = 3'b111;
        ntf_d    = 1'b1;
      end else begin
        unique case (mode_q)
          M_HOLD: begin
            if (cnt_q == 4'd1 && in_char_i == CH_BAR) begin
              // Block comment opens
              fl_act_d   = 1'b1;
              fl_idx_d   = '0;
              fl_n_d     = 4'd1;
              fl_cls_d   = CLS_BLOCK;
              tail_v_d   = 1'b1;
              tail_ch_d  = in_char_i;
              tail_cls_d = CLS_BLOCK;
              tail_ts_d  = 1'b0;
              cnt_d      = '0;
              depth_d    = DEPTH_BITS'(1);
              mode_d     = M_BLOCK;
            end else if (live == 3'b000) begin
              // Not a directive: held bytes become a line comment
              fl_act_d  = 1'b1;
              fl_idx_d  = '0;
              fl_n_d    = cnt_q;
              fl_cls_d  = CLS_LINE;
              tail_v_d  = 1'b1;
              tail_ch_d = in_char_i;
              cnt_d     = '0;
              cand_d    = '0;
              if (in_char_i == CH_NL) begin
                tail_cls_d = CLS_NEWLINE;
                tail_ts_d  = 1'b1;
                ntf_d      = 1'b1;
                mode_d     = M_CODE;
              end else begin
                tail_cls_d = CLS_LINE;
                tail_ts_d  = 1'b0;
                mode_d     = M_LINE;
              end
            end else begin
              // Hold the byte; a complete word releases the line as code
              buf_we = 1'b1;
              cand_d = live;
              cnt_d  = cnt_q + 4'd1;
              if (done_word) begin
                fl_act_d = 1'b1;
                fl_idx_d = '0;
                fl_n_d   = cnt_q + 4'd1;
                fl_cls_d = CLS_CODE;
                cnt_d    = '0;
                mode_d   = M_DIRL;
              end
            end
          end
          M_BLOCK: begin
            if (pend_v_q) begin
              push_o       = 1'b1;
              push_entry_o = mk(pend_q, CLS_BLOCK, 1'b0, 1'b0, drop_q);
              pend_v_d     = 1'b0;
              pend_d       = '0;
              if ((pend_q == CH_HASH && in_char_i == CH_BAR) ||
                  (pend_q == CH_BAR && in_char_i == CH_HASH)) begin
                tail_v_d   = 1'b1;
                tail_ch_d  = in_char_i;
                tail_cls_d = CLS_BLOCK;
                tail_ts_d  = 1'b0;
                if (pend_q == CH_HASH) begin
                  if (depth_q < DEPTH_MAX) depth_d = depth_q + 1'b1;
                end else begin
                  if (depth_q != '0) depth_d = depth_q - 1'b1;
                  if (depth_q <= DEPTH_BITS'(1)) begin
                    mode_d = M_CODE;
                    ntf_d  = 1'b1;
                  end
                end
              end else if (in_char_i == CH_HASH || in_char_i == CH_BAR) begin
                pend_d   = in_char_i;
                pend_v_d = 1'b1;
              end else begin
                tail_v_d   = 1'b1;
                tail_ch_d  = in_char_i;
                tail_cls_d = CLS_BLOCK;
                tail_ts_d  = 1'b0;
              end
            end else if (in_char_i == CH_HASH || in_char_i == CH_BAR) begin
              pend_d   = in_char_i;
              pend_v_d = 1'b1;
            end else begin
              push_o       = 1'b1;
              push_entry_o = mk(in_char_i, CLS_BLOCK, 1'b0, 1'b1, drop_q);
            end
          end
          M_LINE, M_DIRL: begin
            push_o = 1'b1;
            if (in_char_i == CH_NL) begin
              push_entry_o = mk(in_char_i, CLS_NEWLINE, 1'b1, 1'b1, drop_q);
              ntf_d        = 1'b1;
              mode_d       = M_CODE;
            end else begin
              push_entry_o = mk(in_char_i, (mode_q == M_LINE) ? CLS_LINE : CLS_CODE,
                                1'b0, 1'b1, drop_q);
            end
          end
          default: begin
            mode_d = M_CODE;
            if (in_char_i == CH_NL) begin
              push_o       = 1'b1;
              push_entry_o = mk(in_char_i, CLS_NEWLINE, 1'b1, 1'b1, drop_q);
              ntf_d        = 1'b1;
            end else if (in_char_i == CH_HASH) begin
              buf_we = 1'b1;
              buf_wa = '0;
              cnt_d  = 4'd1;
              cand_d = 3'b111;
              mode_d = M_HOLD;
            end else begin
              push_o       = 1'b1;
              push_entry_o = mk(in_char_i, CLS_CODE, ntf_q, 1'b1, drop_q);
              ntf_d        = 1'b0;
            end
          end
        endcase
        // An item push is last only when nothing follows it
        push_entry_o.last = !tail_v_d && !fl_act_d;
      end
    end
  end

  // Hold the directive bytes
  always_ff @(posedge clk_i) begin
    if (buf_we) buf_q[buf_wa] <= in_char_i;
  end

  // Advance lexer and sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= M_CODE;
      depth_q    <= '0;
      pend_q     <= '0;
      pend_v_q   <= 1'b0;
      cnt_q      <= '0;
      cand_q     <= 3'b111;
      ntf_q      <= 1'b1;
      drop_q     <= 1'b0;
      fl_act_q   <= 1'b0;
      fl_idx_q   <= '0;
      fl_n_q     <= '0;
      fl_cls_q   <= CLS_CODE;
      tail_v_q   <= 1'b0;
      tail_ch_q  <= '0;
      tail_cls_q <= CLS_CODE;
      tail_ts_q  <= 1'b0;
    end else begin
      mode_q     <= mode_d;
      depth_q    <= depth_d;
      pend_q     <= pend_d;
      pend_v_q   <= pend_v_d;
      cnt_q      <= cnt_d;
      cand_q     <= cand_d;
      ntf_q      <= ntf_d;
      fl_act_q   <= fl_act_d;
      fl_idx_q   <= fl_idx_d;
      fl_n_q     <= fl_n_d;
      fl_cls_q   <= fl_cls_d;
      tail_v_q   <= tail_v_d;
      tail_ch_q  <= tail_ch_d;
      tail_cls_q <= tail_cls_d;
      tail_ts_q  <= tail_ts_d;
      if (cfg_valid_i) drop_q <= cfg_data_i;
    end
  end

  // No new byte while held bytes drain
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fl_act_q || tail_v_q) |-> !in_ready_o) else $error("front accepted while draining");
  a_depth_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DEPTH_MAX) else $error("nest depth beyond limit");
  a_hold_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == M_HOLD) |-> (cnt_q != 4'd0 && cnt_q < 4'd9)) else $error("bad hold count");

endmodule

`default_nettype wire

### hw/rtl/ncc_queue.sv
// Two-entry queue between front and back end.
// Depends on ncc_pkg for the entry type.
`default_nettype none

module ncc_queue import ncc_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire entry_t push_entry_i,
  output logic        full_o,
  input  wire logic   pop_i,
  output logic        valid_o,
  output entry_t      head_o
);

  entry_t     mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign head_o  = mem_q[rp_q];

  // Store pushed entries
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= push_entry_i;
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

`default_nettype wire

### hw/rtl/ncc_back.sv
// Back end: tracks line and column, drops hidden results, registers output.
// Depends on ncc_pkg; drained from ncc_queue.
`default_nettype none

module ncc_back import ncc_pkg::*; #(
  parameter int unsigned LINE_BITS   = 24,
  parameter int unsigned COLUMN_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_valid_i,
  input  wire entry_t             q_head_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [7:0]              out_char_o,
  output logic [2:0]              char_class_o,
  output logic                    token_start_o,
  output logic [LINE_BITS-1:0]    line_number_o,
  output logic [COLUMN_BITS-1:0]  column_number_o,
  output logic                    last_of_run_o
);

  logic [LINE_BITS-1:0]   line_q, line_d;
  logic [COLUMN_BITS-1:0] col_q, col_d;
  logic                   ov_q;

  assign pop_o       = q_valid_i && (!ov_q || out_ready_i);
  assign out_valid_o = ov_q;

  // Position after this entry
  always_comb begin
    line_d = line_q;
    col_d  = col_q;
    if (q_head_i.cls == CLS_END) begin
      line_d = LINE_BITS'(1);
      col_d  = COLUMN_BITS'(1);
    end else if (q_head_i.ch == CH_NL) begin
      if (line_q != '1) line_d = line_q + 1'b1;
      col_d = COLUMN_BITS'(1);
    end else if (col_q != '1) begin
      col_d = col_q + 1'b1;
    end
  end

  // Capture visible results
  always_ff @(posedge clk_i) begin
    if (pop_o && q_head_i.vis) begin
      out_char_o      <= q_head_i.ch;
      char_class_o    <= q_head_i.cls;
      token_start_o   <= q_head_i.ts;
      line_number_o   <= line_q;
      column_number_o <= col_q;
      last_of_run_o   <= q_head_i.last;
    end
  end

  // Hold counters and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q <= LINE_BITS'(1);
      col_q  <= COLUMN_BITS'(1);
      ov_q   <= 1'b0;
    end else begin
      if (pop_o) begin
        line_q <= line_d;
        col_q  <= col_d;
      end
      if (pop_o && q_head_i.vis) ov_q <= 1'b1;
      else if (out_ready_i)      ov_q <= 1'b0;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/nested_comment_classifier_unit.sv
// Path: an accepted byte is written into the queue, then into the output register.
// Throughput: one byte per cycle while the queue has room; an item with two results
// holds off the next item until both are pushed, and a held prefix drains at one byte a cycle.
// Reset: asynchronous, active low; code mode, line 1, column 1, strip off.
// Depends on ncc_pkg, the channel interfaces, ncc_front, ncc_queue, ncc_back.
`default_nettype none

module nested_comment_classifier_unit import ncc_pkg::*; #(
  parameter int unsigned MAX_DEPTH   = 255,
  parameter int unsigned LINE_BITS   = 24,
  parameter int unsigned COLUMN_BITS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ncc_in_if.sink    in_ch,
  ncc_out_if.source out_ch,
  ncc_cfg_if.sink   cfg_ch
);

  localparam int unsigned DEPTH_BITS = $clog2(MAX_DEPTH + 1);

  logic   q_full, push, pop, q_valid;
  entry_t push_entry, q_head;

  assign cfg_ch.ready = 1'b1;

  ncc_front #(
    .MAX_DEPTH  (MAX_DEPTH),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_ch.valid),
    .in_ready_o   (in_ch.ready),
    .in_char_i    (in_ch.in_char),
    .end_marker_i (in_ch.end_marker),
    .cfg_valid_i  (cfg_ch.valid),
    .cfg_data_i   (cfg_ch.data),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  ncc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .pop_i        (pop),
    .valid_o      (q_valid),
    .head_o       (q_head)
  );

  ncc_back #(
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_head_i        (q_head),
    .pop_o           (pop),
    .out_valid_o     (out_ch.valid),
    .out_ready_i     (out_ch.ready),
    .out_char_o      (out_ch.out_char),
    .char_class_o    (out_ch.char_class),
    .token_start_o   (out_ch.token_start),
    .line_number_o   (out_ch.line_number),
    .column_number_o (out_ch.column_number),
    .last_of_run_o   (out_ch.last_of_run)
  );

endmodule

`default_nettype wire

### verif/nested_comment_classifier_unit_tb.sv
// Self-checking testbench for nested_comment_classifier_unit: directed and random source text.
// Holds its own classifier model and checks every output transfer against it.
// Depends on ncc_pkg and the ncc_in_if, ncc_out_if and ncc_cfg_if interfaces.
`timescale 1ns / 1ps

module nested_comment_classifier_unit_tb;
  import ncc_pkg::*;

  localparam int unsigned DEPTH_MAX  = 255;
  localparam int unsigned CYCLE_CAP  = 2000000;
  localparam int unsigned SETTLE_CYC = 12;
  localparam logic [23:0] LINE_TOP   = 24'hFFFFFF;
  localparam logic [15:0] COL_TOP    = 16'hFFFF;

  typedef struct {
    logic [7:0]  ch;
    cls_e        cls;
    logic        ts;
    logic [23:0] ln;
    logic [15:0] cn;
    logic        last;
  } lex_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ncc_in_if  in_ch ();
  ncc_out_if out_ch ();
  ncc_cfg_if cfg_ch ();

  nested_comment_classifier_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Model state of the classifier
  lex_result_t expected_q[$];
  mode_e       lx_mode;
  int unsigned lx_depth;
  logic [7:0]  lx_pend;
  logic        lx_pend_v;
  logic [7:0]  lx_buf [9];
  int unsigned lx_cnt;
  logic [2:0]  lx_cand;
  logic [23:0] lx_line;
  logic [15:0] lx_col;
  logic        lx_newtok;
  logic        strip_on;
  int unsigned item_results;
  string       dir_words [3] = '{"#extern", "#register", "#include"};

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned hold_len;
  int unsigned cycles;
  int unsigned errors;
  int unsigned n_items;
  int unsigned n_results;
  int unsigned n_ends;

  function automatic void lex_emit(logic [7:0] c, cls_e k, logic t);
    lex_result_t r;
    if (!(strip_on && (k == CLS_LINE || k == CLS_BLOCK))) begin
      r.ch = c; r.cls = k; r.ts = t; r.ln = lx_line; r.cn = lx_col; r.last = 1'b0;
      expected_q.insert(expected_q.size(), r);
      item_results++;
    end
    if (k != CLS_END) begin
      if (c == CH_NL) begin
        if (lx_line != LINE_TOP) lx_line++;
        lx_col = 16'd1;
      end else if (lx_col != COL_TOP) begin
        lx_col++;
      end
    end
  endfunction

  function automatic void lex_flush(cls_e k);
    for (int unsigned i = 0; i < lx_cnt && i < 9; i++) lex_emit(lx_buf[i], k, i == 0);
    lx_cnt = 0;
  endfunction

  function automatic void lex_clear();
    lx_mode = M_CODE; lx_depth = 0; lx_pend = 8'd0; lx_pend_v = 1'b0;
    lx_cnt = 0; lx_cand = 3'b111; lx_line = 24'd1; lx_col = 16'd1; lx_newtok = 1'b1;
  endfunction

  // Directive prefix: decide between block open, directive and line comment
  function automatic void lex_hold(logic [7:0] b);
    logic [2:0] live;
    live = 3'b000;
    if (lx_cnt == 1 && b == CH_BAR) begin
      lex_emit(CH_HASH, CLS_BLOCK, 1'b1);
      lex_emit(CH_BAR, CLS_BLOCK, 1'b0);
      lx_cnt = 0; lx_depth = 1; lx_mode = M_BLOCK;
      return;
    end
    for (int k = 0; k < 3; k++)
      if (lx_cand[k] && lx_cnt < dir_words[k].len() && dir_words[k][lx_cnt] == b)
        live[k] = 1'b1;
    lx_cand = live;
    if (live == 3'b000) begin
      lex_flush(CLS_LINE);
      if (b == CH_NL) begin
        lex_emit(b, CLS_NEWLINE, 1'b1); lx_newtok = 1'b1; lx_mode = M_CODE;
      end else begin
        lex_emit(b, CLS_LINE, 1'b0); lx_mode = M_LINE;
      end
      return;
    end
    if (lx_cnt < 9) lx_buf[lx_cnt] = b;
    lx_cnt++;
    for (int k = 0; k < 3; k++)
      if (live[k] && dir_words[k].len() == lx_cnt) begin
        lex_flush(CLS_CODE); lx_mode = M_DIRL;
        return;
      end
  endfunction

  // Inside a block: pair bytes greedily, track the depth
  function automatic void lex_block(logic [7:0] b);
    logic [7:0] p;
    if (lx_pend_v) begin
      p = lx_pend; lx_pend_v = 1'b0; lx_pend = 8'd0;
      if (p == CH_HASH && b == CH_BAR) begin
        lex_emit(p, CLS_BLOCK, 1'b0); lex_emit(b, CLS_BLOCK, 1'b0);
        if (lx_depth < DEPTH_MAX) lx_depth++;
        return;
      end
      if (p == CH_BAR && b == CH_HASH) begin
        lex_emit(p, CLS_BLOCK, 1'b0); lex_emit(b, CLS_BLOCK, 1'b0);
        if (lx_depth > 0) lx_depth--;
        if (lx_depth == 0) begin
          lx_mode = M_CODE; lx_newtok = 1'b1;
        end
        return;
      end
      lex_emit(p, CLS_BLOCK, 1'b0);
    end
    if (b == CH_HASH || b == CH_BAR) begin
      lx_pend = b; lx_pend_v = 1'b1;
    end else begin
      lex_emit(b, CLS_BLOCK, 1'b0);
    end
  endfunction

  function automatic void lex_predict(logic [7:0] b, logic e);
    item_results = 0;
    if (e) begin
      if (lx_mode == M_HOLD) begin
        lex_flush(CLS_LINE);
      end else if (lx_mode == M_BLOCK && lx_pend_v) begin
        lx_pend_v = 1'b0; lex_emit(lx_pend, CLS_BLOCK, 1'b0);
      end
      lex_emit(8'd0, CLS_END, 1'b1);
      lex_clear();
    end else begin
      case (lx_mode)
        M_HOLD:  lex_hold(b);
        M_BLOCK: lex_block(b);
        M_LINE, M_DIRL: begin
          if (b == CH_NL) begin
            lex_emit(b, CLS_NEWLINE, 1'b1); lx_newtok = 1'b1; lx_mode = M_CODE;
          end else begin
            lex_emit(b, lx_mode == M_LINE ? CLS_LINE : CLS_CODE, 1'b0);
          end
        end
        default: begin
          lx_mode = M_CODE;
          if (b == CH_NL) begin
            lex_emit(b, CLS_NEWLINE, 1'b1); lx_newtok = 1'b1;
          end else if (b == CH_HASH) begin
            lx_buf[0] = b; lx_cnt = 1; lx_cand = 3'b111; lx_mode = M_HOLD;
          end else begin
            lex_emit(b, CLS_CODE, lx_newtok); lx_newtok = 1'b0;
          end
        end
      endcase
    end
    if (item_results > 0) expected_q[$].last = 1'b1;
  endfunction

  // Offer one item, idling at random first; valid stays high into the next item
  task automatic send_item(input logic [7:0] c, input logic e);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.in_char    <= c;
    in_ch.end_marker <= e;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    lex_predict(c, e);
    n_items++;
    if (e) n_ends++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic send_end();
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Drop valid and wait until every expected result has arrived, then settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_strip(input logic v);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    strip_on = v;
    cfg_ch.valid <= 1'b0;
  endtask

  // Receiver: random idling, or a long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_len > 0) begin
      out_ch.ready <= 1'b0;
      hold_len <= hold_len - 1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Compare each output transfer with the oldest expected result
  always @(posedge clk_i) begin
    lex_result_t x;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: char %h class %0d", out_ch.out_char,
                                   out_ch.char_class);
      end else begin
        x = expected_q.pop_front();
        if (out_ch.out_char !== x.ch || out_ch.char_class !== x.cls ||
            out_ch.token_start !== x.ts || out_ch.line_number !== x.ln ||
            out_ch.column_number !== x.cn || out_ch.last_of_run !== x.last) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: exp ch %h cls %0d ts %b ln %0d col %0d last %b",
                     x.ch, x.cls, x.ts, x.ln, x.cn, x.last);
            $display("          got ch %h cls %0d ts %b ln %0d col %0d last %b",
                     out_ch.out_char, out_ch.char_class, out_ch.token_start,
                     out_ch.line_number, out_ch.column_number, out_ch.last_of_run);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("nested_comment_classifier_unit test failed");
      $finish;
    end
  end

  task automatic test_directed();
    send_text("ab c\n");
    send_item(8'hFF, 1'b0); send_item(8'h00, 1'b0); send_item(CH_NL, 1'b0);
    send_text("#extern x#|\n#register\n#include y\n#inc z\n#\n");
    send_text("#| a #| b |# c |# d #|#|# e");
    send_end();
    send_text("#");
    send_end();
    send_text("#exte");
    send_end();
    send_text("#|x|");
    send_end();
  endtask

  task automatic test_strip_mode();
    write_strip(1'b1);
    send_text("q #line\n#|blk|#w #include k\n#|#|");
    send_end();
    write_strip(1'b0);
  endtask

  // Open several levels, then close one more than were opened
  task automatic test_deep_nesting();
    repeat (8) send_text("#|");
    repeat (9) send_text("|#");
    send_text("\n");
    send_end();
  endtask

  // Mostly well-formed fragments with random content, some noise
  task automatic random_fragment();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    case (pick)
      0, 1:    send_item(8'($urandom_range(0, 255)), 1'b0);
      2:       send_item(CH_NL, 1'b0);
      3:       send_text("#|");
      4:       send_text("|#");
      5:       send_text(dir_words[$urandom_range(0, 2)]);
      6:       send_item(CH_HASH, 1'b0);
      7:       send_item(CH_BAR, 1'b0);
      8:       send_text("#regi");
      9:       send_end();
      default: send_item(8'($urandom_range(32, 126)), 1'b0);
    endcase
  endtask

  task automatic test_random(input int unsigned count);
    int unsigned stop;
    stop = n_items + count;
    while (n_items < stop) random_fragment();
    send_end();
  endtask

  // Long receiver hold-off while items keep coming, so the block fills and stalls
  task automatic test_backpressure();
    hold_len = 200;
    for (int i = 0; i < 40; i++) random_fragment();
  endtask

  initial begin
    in_ch.valid = 1'b0; in_ch.in_char = 8'd0; in_ch.end_marker = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.data = 1'b0;
    out_ch.ready = 1'b0;
    hold_len = 0; cycles = 0; errors = 0;
    n_items = 0; n_results = 0; n_ends = 0;
    strip_on = 1'b0;
    lex_clear();
    tx_idle_pct = 23; rx_idle_pct = 57;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_strip_mode();
    test_random(28);
    write_strip(1'b1);
    test_random(28);
    write_strip(1'b0);
    tx_idle_pct = 57; rx_idle_pct = 23;
    test_backpressure();
    test_random(28);
    write_strip(1'b1);
    test_random(28);
    write_strip(1'b0);
    tx_idle_pct = 0; rx_idle_pct = 0;
    test_deep_nesting();
    test_random(28);
    write_strip(1'b1);
    test_random(28);
    drain();

    $display("covered %0d items, %0d results, %0d end items, strip on and off,",
             n_items, n_results, n_ends);
    $display("nested blocks with an extra close, directives and a long output hold-off");
    if (errors == 0) begin
      $display("nested_comment_classifier_unit test passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("nested_comment_classifier_unit test failed");
    end
    $finish;
  end

endmodule
